>>> rtl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared sizes, types and the logistic lookup table of the activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int INDEX_BITS   = 7;
  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int MAG_BITS     = FRAC_BITS + 3;
  localparam int SEGS         = 1 << INDEX_BITS;
  localparam int SEG_SHIFT    = MAG_BITS - INDEX_BITS;
  localparam int LUT_BITS     = FRAC_BITS + 1;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int DERIV_K      = 2731;
  localparam int DERIV_K_BITS = 12;
  localparam int DERIV_SHIFT  = 2 * FRAC_BITS;
  localparam int MAGW_BITS    = (DATA_WIDTH > MAG_BITS) ? DATA_WIDTH : MAG_BITS + 1;
  localparam int XW_BITS      = MAGW_BITS + 1;
  localparam int INTERP_BITS  = LUT_BITS + SEG_SHIFT + 1;
  localparam int PROD_BITS    = 2 * LUT_BITS;
  localparam int DPROD_BITS   = PROD_BITS + DERIV_K_BITS;

  typedef logic [DATA_WIDTH-1:0]         data_t;
  typedef logic [LUT_BITS-1:0]           lut_t;
  typedef logic [INDEX_BITS-1:0]         idx_t;
  typedef logic [INDEX_BITS:0]           ridx_t;
  typedef logic [SEG_SHIFT-1:0]          frac_t;
  typedef logic signed [XW_BITS-1:0]     xw_t;
  typedef logic [INTERP_BITS-1:0]        interp_t;
  typedef logic [PROD_BITS-1:0]          prod_t;
  typedef logic [DPROD_BITS-1:0]         dprod_t;
  typedef lut_t                          rom_t [0:SEGS];

  typedef enum logic [1:0] {
    FN_LOGISTIC  = 2'd0,
    FN_DLOGISTIC = 2'd1,
    FN_RELU      = 2'd2,
    FN_DRELU     = 2'd3
  } func_e;

  // decoded operand leaving the input stage
  typedef struct packed {
    func_e func;
    logic  neg;
    logic  sat;
    idx_t  idx;
    frac_t frac;
    lut_t  clamp;
    data_t simple;
  } dec_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  localparam xw_t     ONE_XW      = xw_t'(ONE_Q);
  localparam xw_t     MAG_LIMIT   = xw_t'(1) <<< MAG_BITS;
  localparam interp_t INTERP_HALF = interp_t'(1) << (SEG_SHIFT - 1);
  localparam logic [63:0] WIDE_ONE = 64'd1 << 60;
  localparam logic [63:0] ROM_STEP = (WIDE_ONE / 64'(3 * SEGS)) * 64'd16;

  // (a*b) >> 60 on Q60 operands
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // shift-subtract quotient, only used while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-v) in Q60 by a truncated series, elaboration only
  function automatic logic [63:0] exp_neg_q60(input logic [63:0] v);
    logic [63:0] term;
    logic [63:0] sum;
    term = WIDE_ONE;
    sum  = WIDE_ONE;
    for (int k = 1; k <= 30; k++) begin
      term = div_u64(mul_q60(term, v), 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // logistic table, entry i = round(4096/(1+exp(-i/(3*SEGS/16))))
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] factor;
    logic [63:0] e;
    logic [63:0] d2;
    logic [63:0] q;
    factor = exp_neg_q60(ROM_STEP);
    e      = WIDE_ONE;
    for (int i = 0; i <= SEGS; i++) begin
      d2     = (WIDE_ONE + e) >> 20;
      q      = div_u64((64'd1 << 53) + d2, d2 << 1);
      rom[i] = lut_t'(q);
      e      = mul_q60(e, factor);
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

>>> rtl/neural_activation_unit.sv
// ----------------------------------------------------------------------------
// neural_activation_unit
// Streaming activation function unit: logistic, logistic derivative, ReLU
// and ReLU derivative on signed Q4.12 operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i, func_i, x_value_i; the unit answers with
//   in_stall_o. A request is taken at a clock edge with in_valid_i high and
//   in_stall_o low.
//   Output channel: out_valid_o, y_value_o; the receiver answers with
//   out_stall_i. Each request yields exactly one result, in request order.
//   Throughput: one request per cycle while out_stall_i is low. A
//   request passes the four register stages in order (input/decode, table
//   read and first product, interpolation and derivative scale, output
//   register); out_valid_o is the valid bit of the output register.
//   Stalls: each stage holds its item while the one after it is full and
//   blocked, so bubbles are squeezed out; in_stall_o rises only when all four
//   stages hold an item and out_stall_i is high.
//   Reset: rst_ni clears every stage valid bit at once; the pipeline comes
//   out of reset empty and ready to take a request.
// ----------------------------------------------------------------------------
module neural_activation_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            func_i,
  input  logic signed [nau_pkg::DATA_WIDTH-1:0] x_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [nau_pkg::DATA_WIDTH-1:0] y_value_o
);

  nau_pkg::adv_t  adv;
  nau_pkg::dec_t  dec;
  nau_pkg::lut_t  sig_y;
  nau_pkg::lut_t  deriv_y;
  nau_pkg::data_t y_d;

  logic v1_q, v2_q, v3_q, v4_q;
  nau_pkg::func_e func2_q, func3_q;
  nau_pkg::data_t simple2_q, simple3_q;
  nau_pkg::data_t y4_q;

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    adv.s4 = !v4_q || !out_stall_i;
    adv.s3 = !v3_q || adv.s4;
    adv.s2 = !v2_q || adv.s3;
    adv.s1 = !v1_q || adv.s2;
  end

  assign in_stall_o = !adv.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv.s1) v1_q <= in_valid_i;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
      if (adv.s4) v4_q <= v3_q;
    end
  end

  nau_front u_front (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .func_i    (func_i),
    .x_value_i (x_value_i),
    .dec_o     (dec)
  );

  nau_sig_path u_sig_path (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .dec_i   (dec),
    .sig_y_o (sig_y)
  );

  nau_deriv_path u_deriv_path (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .dec_i     (dec),
    .deriv_y_o (deriv_y)
  );

  // function code and relu result ride alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      func2_q   <= dec.func;
      simple2_q <= dec.simple;
    end
    if (adv.s3) begin
      func3_q   <= func2_q;
      simple3_q <= simple2_q;
    end
    if (adv.s4) begin
      y4_q <= y_d;
    end
  end

  always_comb begin
    unique case (func3_q)
      nau_pkg::FN_LOGISTIC:  y_d = nau_pkg::data_t'(sig_y);
      nau_pkg::FN_DLOGISTIC: y_d = nau_pkg::data_t'(deriv_y);
      nau_pkg::FN_RELU,
      nau_pkg::FN_DRELU:     y_d = simple3_q;
      default:               y_d = simple3_q;
    endcase
  end

  assign out_valid_o = v4_q;
  assign y_value_o   = y4_q;

endmodule

>>> rtl/nau_front.sv
// ----------------------------------------------------------------------------
// nau_front
// Input register stage and operand decode: magnitude, table index and
// fraction, derivative clamp and the ReLU results.
// ----------------------------------------------------------------------------
module nau_front (
  input  logic                clk_i,
  input  nau_pkg::adv_t       adv_i,
  input  logic [1:0]          func_i,
  input  logic signed [nau_pkg::DATA_WIDTH-1:0] x_value_i,
  output nau_pkg::dec_t       dec_o
);

  nau_pkg::func_e func_q;
  nau_pkg::data_t x_q;
  nau_pkg::xw_t   xe;
  nau_pkg::xw_t   mag;

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      func_q <= nau_pkg::func_e'(func_i);
      x_q    <= x_value_i;
    end
  end

  always_comb begin
    xe  = nau_pkg::xw_t'(signed'(x_q));
    mag = x_q[nau_pkg::DATA_WIDTH-1] ? -xe : xe;

    dec_o.func = func_q;
    dec_o.neg  = x_q[nau_pkg::DATA_WIDTH-1];
    dec_o.sat  = (mag >= nau_pkg::MAG_LIMIT);
    dec_o.idx  = mag[nau_pkg::MAG_BITS-1:nau_pkg::SEG_SHIFT];
    dec_o.frac = mag[nau_pkg::SEG_SHIFT-1:0];

    if (xe < 0) begin
      dec_o.clamp = '0;
    end else if (xe > nau_pkg::ONE_XW) begin
      dec_o.clamp = nau_pkg::lut_t'(nau_pkg::ONE_Q);
    end else begin
      dec_o.clamp = xe[nau_pkg::LUT_BITS-1:0];
    end

    // relu and its derivative are finished here and only ride along
    if (func_q == nau_pkg::FN_RELU) begin
      dec_o.simple = (xe < 0) ? '0 : x_q;
    end else begin
      dec_o.simple = (xe > 0) ? nau_pkg::data_t'(nau_pkg::ONE_Q) : '0;
    end
  end

endmodule

>>> rtl/nau_sig_path.sv
// ----------------------------------------------------------------------------
// nau_sig_path
// Logistic datapath: table read of two neighbors, then interpolation
// multiply, then the final add and mirror for negative operands.
// ----------------------------------------------------------------------------
module nau_sig_path (
  input  logic          clk_i,
  input  nau_pkg::adv_t adv_i,
  input  nau_pkg::dec_t dec_i,
  output nau_pkg::lut_t sig_y_o
);

  nau_pkg::ridx_t  lo_addr;
  nau_pkg::ridx_t  hi_addr;
  nau_pkg::lut_t   lo_val;
  nau_pkg::lut_t   hi_val;
  nau_pkg::lut_t   diff_d;
  nau_pkg::frac_t  frac_d;
  nau_pkg::interp_t interp_d;
  nau_pkg::lut_t   sum;

  nau_pkg::lut_t   lo2_q;
  nau_pkg::lut_t   diff2_q;
  nau_pkg::frac_t  frac2_q;
  logic            neg2_q;
  nau_pkg::lut_t   lo3_q;
  nau_pkg::interp_t interp3_q;
  logic            neg3_q;

  always_comb begin
    // saturated magnitudes read the last entry with zero slope
    if (dec_i.sat) begin
      lo_addr = nau_pkg::ridx_t'(nau_pkg::SEGS);
      hi_addr = nau_pkg::ridx_t'(nau_pkg::SEGS);
      frac_d  = '0;
    end else begin
      lo_addr = {1'b0, dec_i.idx};
      hi_addr = {1'b0, dec_i.idx} + nau_pkg::ridx_t'(1);
      frac_d  = dec_i.frac;
    end
    lo_val = nau_pkg::SIG_ROM[lo_addr];
    hi_val = nau_pkg::SIG_ROM[hi_addr];
    diff_d = (hi_val < lo_val) ? '0 : hi_val - lo_val;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      lo2_q   <= lo_val;
      diff2_q <= diff_d;
      frac2_q <= frac_d;
      neg2_q  <= dec_i.neg;
    end
  end

  assign interp_d = nau_pkg::interp_t'(diff2_q) * nau_pkg::interp_t'(frac2_q)
                  + nau_pkg::INTERP_HALF;

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      lo3_q     <= lo2_q;
      interp3_q <= interp_d;
      neg3_q    <= neg2_q;
    end
  end

  always_comb begin
    sum     = lo3_q + nau_pkg::lut_t'(interp3_q >> nau_pkg::SEG_SHIFT);
    sig_y_o = neg3_q ? nau_pkg::lut_t'(nau_pkg::ONE_Q) - sum : sum;
  end

endmodule

>>> rtl/nau_deriv_path.sv
// ----------------------------------------------------------------------------
// nau_deriv_path
// Logistic derivative: c*(1-c) in one stage, scaling by 2/3 in the next.
// ----------------------------------------------------------------------------
module nau_deriv_path (
  input  logic          clk_i,
  input  nau_pkg::adv_t adv_i,
  input  nau_pkg::dec_t dec_i,
  output nau_pkg::lut_t deriv_y_o
);

  nau_pkg::lut_t   one_minus;
  nau_pkg::dprod_t dprod;
  nau_pkg::prod_t  prod2_q;
  nau_pkg::lut_t   deriv3_q;

  assign one_minus = nau_pkg::lut_t'(nau_pkg::ONE_Q) - dec_i.clamp;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      prod2_q <= nau_pkg::prod_t'(dec_i.clamp) * nau_pkg::prod_t'(one_minus);
    end
  end

  assign dprod = nau_pkg::dprod_t'(prod2_q) * nau_pkg::dprod_t'(nau_pkg::DERIV_K);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      deriv3_q <= dprod[nau_pkg::DERIV_SHIFT +: nau_pkg::LUT_BITS];
    end
  end

  assign deriv_y_o = deriv3_q;

endmodule

>>> rtl/nau_checker.sv
// ----------------------------------------------------------------------------
// nau_checker
// Port-level checks of the activation unit, bound to the top level.
// ----------------------------------------------------------------------------
module nau_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [nau_pkg::DATA_WIDTH-1:0] y_value_o
);

  // a blocked result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(y_value_o))
    else $error("result changed while stalled");

  // input backpressure only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output not blocked");

  // with no output stall an accepted request reaches out_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("request did not come out after four cycles");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty in reset");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .y_value_o   (y_value_o)
);
